// ----- rtl/fpmk_pkg.sv -----
// Shared types, codes and helpers for the front panel mode key block.
// No dependencies; used by every module under rtl/.
package fpmk_pkg;

  localparam int unsigned CountWidth = 8;
  localparam int unsigned IndexWidth = 2;

  typedef logic [CountWidth-1:0] count_t;

  // Configuration register indexes
  typedef enum logic [IndexWidth-1:0] {
    REG_STARTUP_WINDOW = 2'd0,
    REG_RESET_THRESHOLD = 2'd1,
    REG_STEP_LOCKOUT = 2'd2
  } reg_index_t;

  localparam count_t StartupWindowReset = 8'd12;
  localparam count_t ResetThresholdReset = 8'd10;
  localparam count_t StepLockoutReset = 8'd3;
  localparam count_t SinceStepReset = 8'd255;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_AUTO = 3'd1,
    EV_MANUAL = 3'd2,
    EV_FLASHING = 3'd3,
    EV_ALLRED = 3'd4,
    EV_STEP = 3'd5
  } event_t;

  typedef struct packed {
    logic mode_auto;
    logic mode_manual;
    logic mode_flashing;
    logic mode_allred;
    logic mode_step;
  } modes_t;

  typedef struct packed {
    modes_t modes;
    count_t uptime_seconds;
    count_t hold_poll_count;
    count_t since_step_seconds;
  } state_t;

  typedef struct packed {
    count_t startup_window_seconds;
    count_t reset_press_threshold;
    count_t step_lockout_seconds;
  } cfg_t;

  typedef struct packed {
    logic second_tick;
    logic step_key_level;
    logic flashing_key_level;
    logic auto_key_level;
    logic manual_key_level;
    logic allred_key_level;
  } poll_t;

  typedef struct packed {
    event_t event_code;
    logic lamp_auto;
    logic lamp_manual;
    logic lamp_flashing;
    logic lamp_allred;
    logic lamp_step;
    logic lamps_update;
    logic factory_reset;
  } result_t;

  function automatic count_t sat_inc(input count_t v);
    sat_inc = (v == '1) ? v : count_t'(v + 1'b1);
  endfunction

endpackage

// ----- rtl/fpmk_cfg.sv -----
// Configuration registers of the front panel mode key block.
// Depends on fpmk_pkg.
module fpmk_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [fpmk_pkg::IndexWidth-1:0]    index,
  input  fpmk_pkg::count_t                   wr_data,
  output fpmk_pkg::cfg_t                     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.startup_window_seconds <= fpmk_pkg::StartupWindowReset;
      cfg.reset_press_threshold <= fpmk_pkg::ResetThresholdReset;
      cfg.step_lockout_seconds <= fpmk_pkg::StepLockoutReset;
    end else if (wr_en) begin
      // unknown indexes are dropped
      case (index)
        fpmk_pkg::REG_STARTUP_WINDOW:  cfg.startup_window_seconds <= wr_data;
        fpmk_pkg::REG_RESET_THRESHOLD: cfg.reset_press_threshold <= wr_data;
        fpmk_pkg::REG_STEP_LOCKOUT:    cfg.step_lockout_seconds <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/fpmk_decide.sv -----
// Per-poll decision logic: next state and result from the current state.
// Depends on fpmk_pkg.
module fpmk_decide (
  input  fpmk_pkg::cfg_t    cfg,
  input  fpmk_pkg::state_t  state,
  input  fpmk_pkg::poll_t   poll,
  output fpmk_pkg::state_t  state_next,
  output fpmk_pkg::result_t result
);

  logic step_key, flash_key, auto_key, manual_key, allred_key;
  fpmk_pkg::count_t uptime, since_step, hold;
  logic in_window, freset, step_ok;
  fpmk_pkg::modes_t modes;
  fpmk_pkg::event_t ev;

  assign step_key = ~poll.step_key_level;
  assign flash_key = ~poll.flashing_key_level;
  assign auto_key = ~poll.auto_key_level;
  assign manual_key = ~poll.manual_key_level;
  assign allred_key = ~poll.allred_key_level;

  // Advance the seconds counters before the keys are judged
  assign uptime = poll.second_tick ? fpmk_pkg::sat_inc(state.uptime_seconds)
                                   : state.uptime_seconds;
  assign in_window = uptime < cfg.startup_window_seconds;

  assign step_ok = step_key && !state.modes.mode_flashing && !state.modes.mode_allred;

  always_comb begin
    since_step = poll.second_tick ? fpmk_pkg::sat_inc(state.since_step_seconds)
                                  : state.since_step_seconds;
    hold = state.hold_poll_count;
    modes = state.modes;
    ev = fpmk_pkg::EV_NONE;
    freset = 1'b0;
    if (in_window) begin
      if (flash_key) begin
        hold = fpmk_pkg::sat_inc(state.hold_poll_count);
      end
      freset = hold >= cfg.reset_press_threshold;
    end else if (state.modes.mode_auto) begin
      if (manual_key) begin
        modes.mode_auto = 1'b0;
        modes.mode_manual = 1'b1;
        ev = fpmk_pkg::EV_MANUAL;
      end
    end else if (state.modes.mode_manual) begin
      priority if (auto_key) begin
        modes = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
        ev = fpmk_pkg::EV_AUTO;
      end else if (flash_key) begin
        modes = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0};
        ev = fpmk_pkg::EV_FLASHING;
      end else if (allred_key) begin
        modes = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        ev = fpmk_pkg::EV_ALLRED;
      end else if (step_ok && since_step > cfg.step_lockout_seconds) begin
        since_step = '0;
        modes = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
        ev = fpmk_pkg::EV_STEP;
      end
    end
  end

  assign state_next.modes = modes;
  assign state_next.uptime_seconds = uptime;
  assign state_next.hold_poll_count = hold;
  assign state_next.since_step_seconds = since_step;

  assign result.event_code = ev;
  assign result.lamp_auto = modes.mode_auto & ~freset;
  assign result.lamp_manual = modes.mode_manual;
  assign result.lamp_flashing = modes.mode_flashing;
  assign result.lamp_allred = modes.mode_allred;
  assign result.lamp_step = modes.mode_step;
  assign result.lamps_update = (ev != fpmk_pkg::EV_NONE);
  assign result.factory_reset = freset;

endmodule

// ----- rtl/front_panel_mode_keys.sv -----
// Top level of the front panel mode key block: stream ports, poll and
// result registers, mode state. Depends on fpmk_pkg, fpmk_cfg, fpmk_decide.

// One poll transaction in, one result transaction out. A poll is taken into
// the input register, judged against the mode state while it is held there
// and its result lands in the output register. A new poll is accepted every
// cycle unless the output stalls: the only loop is the mode and counter
// state, updated once per judged poll. The input register keeps accepting
// while a result waits for the downstream side; it stalls only when both
// registers are full and the result is not taken. Write the configuration
// registers only while no poll is in flight.
module front_panel_mode_keys (
  input  logic                            clk,
  input  logic                            rst,
  // Poll stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [0] second_tick, [1] step_key_level, [2] flashing_key_level,
  // [3] auto_key_level, [4] manual_key_level, [5] allred_key_level, [7:6] zero
  input  logic [7:0]                      s_tdata,
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [2:0] event_code, [3] lamp_auto, [4] lamp_manual, [5] lamp_flashing,
  // [6] lamp_allred, [7] lamp_step, [8] lamps_update, [9] factory_reset,
  // [15:10] zero
  output logic [15:0]                     m_tdata,
  // Configuration writes
  input  logic                            cfg_wr_en,
  input  logic [fpmk_pkg::IndexWidth-1:0] cfg_index,
  input  fpmk_pkg::count_t                cfg_wr_data
);

  fpmk_pkg::cfg_t    cfg;
  fpmk_pkg::state_t  state, state_next;
  fpmk_pkg::poll_t   poll;
  fpmk_pkg::result_t result_next, result;

  logic in_valid;
  logic out_valid;
  logic advance;

  // Move the held poll on when the output register is free or being emptied
  assign advance = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  fpmk_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cfg_wr_en),
    .index   (cfg_index),
    .wr_data (cfg_wr_data),
    .cfg     (cfg)
  );

  fpmk_decide u_decide (
    .cfg        (cfg),
    .state      (state),
    .poll       (poll),
    .state_next (state_next),
    .result     (result_next)
  );

  // Input register: hold the poll until it is judged
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      poll <= '{s_tdata[0], s_tdata[1], s_tdata[2], s_tdata[3], s_tdata[4], s_tdata[5]};
    end
  end

  // Mode state: advance once per judged poll
  always_ff @(posedge clk) begin
    if (rst) begin
      state.modes <= '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
      state.uptime_seconds <= '0;
      state.hold_poll_count <= '0;
      state.since_step_seconds <= fpmk_pkg::SinceStepReset;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {6'b0, result.factory_reset, result.lamps_update, result.lamp_step,
                    result.lamp_allred, result.lamp_flashing, result.lamp_manual,
                    result.lamp_auto, result.event_code};

endmodule
